@@ hdl/dlt_pkg.sv @@
// Shared types and constants for the dictionary line tokenizer.
// Holds the request payload structs, the byte classes and the token kind codes.
// No dependencies.
package dlt_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int WORK_DEPTH = 2;
  localparam int RESULT_DEPTH = 2;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [3:0] {
    KIND_TEXT      = 4'd0,
    KIND_STRING    = 4'd1,
    KIND_PHONEMES  = 4'd2,
    KIND_DIRECTIVE = 4'd3,
    KIND_CONTENTS  = 4'd4,
    KIND_END       = 4'd5,
    KIND_ERR_BODY  = 4'd6,
    KIND_ERR_SLASH = 4'd7,
    KIND_ERR_QUOTE = 4'd8
  } kind_t;

  typedef struct packed {
    logic is_eol;
    logic is_tab;
    logic is_space;
    logic is_hash;
    logic is_dot;
    logic is_slash;
    logic is_quote;
  } char_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_end;
  } out_item_t;

endpackage

@@ hdl/dlt_fifo.sv @@
// Small first-in first-out queue of register slots used between the tokenizer stages.
// Standalone; no package dependency.
module dlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/dlt_front.sv @@
// Front stage of the tokenizer: takes input requests, classifies each byte and tags it
// with its stream offset. Depends on dlt_pkg.
module dlt_front #(
  parameter int POSITION_BITS = dlt_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dlt_pkg::in_item_t    in_data,
  input  logic                 work_full,
  output logic                 work_push,
  output logic                 work_end,
  output dlt_pkg::char_class_t work_class,
  output logic [POSITION_BITS-1:0] work_pos
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               ch;
  logic                     accept;

  assign ch        = in_data.data_byte;
  assign accept    = push && !work_full;
  assign work_push = accept;
  assign work_end  = in_data.end_of_input;
  assign work_pos  = pos_r;

  always_comb begin
    work_class.is_eol   = (ch == dlt_pkg::CH_CR) || (ch == dlt_pkg::CH_LF);
    work_class.is_tab   = (ch == dlt_pkg::CH_TAB);
    work_class.is_space = (ch == dlt_pkg::CH_SPACE);
    work_class.is_hash  = (ch == dlt_pkg::CH_HASH);
    work_class.is_dot   = (ch == dlt_pkg::CH_DOT);
    work_class.is_slash = (ch == dlt_pkg::CH_SLASH);
    work_class.is_quote = (ch == dlt_pkg::CH_QUOTE);
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = in_data.end_of_input ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ hdl/dlt_back.sv @@
// Back stage of the tokenizer: runs the lexer state machine on classified bytes and
// forms the token results. Depends on dlt_pkg.
module dlt_back #(
  parameter int POSITION_BITS = dlt_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     work_empty,
  input  logic                     work_end,
  input  dlt_pkg::char_class_t     work_class,
  input  logic [POSITION_BITS-1:0] work_pos,
  output logic                     work_pop,
  input  logic                     res_full,
  output logic                     res_push,
  output dlt_pkg::out_item_t       res_data
);

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [9:0] {
    ST_START      = 10'b00_0000_0001,
    ST_LINE       = 10'b00_0000_0010,
    ST_COMMENT    = 10'b00_0000_0100,
    ST_DIRECTIVE  = 10'b00_0000_1000,
    ST_PRE_BODY   = 10'b00_0001_0000,
    ST_BODY       = 10'b00_0010_0000,
    ST_TEXT       = 10'b00_0100_0000,
    ST_PHONEMES   = 10'b00_1000_0000,
    ST_DIR_STRING = 10'b01_0000_0000,
    ST_STRING     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    state_t         state;
    logic           used;
    logic           hit;
    dlt_pkg::kind_t kind;
    pos_t           tstart;
    pos_t           tend;
    pos_t           tbegin;
    pos_t           trim;
  } step_t;

  state_t state_r, state_nxt;
  pos_t   begin_r, begin_nxt;
  pos_t   trim_r, trim_nxt;
  pos_t   nxt_pos;
  step_t  chain [4];
  logic   go;

  function automatic step_t lex_step(step_t p, dlt_pkg::char_class_t c, pos_t pos, pos_t nxt);
    step_t r;
    r = p;
    case (p.state)
      ST_START: begin
        if (c.is_eol || c.is_tab || c.is_space) begin
          r.used = 1'b1;
        end else if (c.is_hash) begin
          r.state = ST_COMMENT;
        end else if (c.is_dot) begin
          r.tbegin = pos;
          r.state  = ST_DIRECTIVE;
        end else if (c.is_slash) begin
          r.tbegin = nxt;
          r.state  = ST_PHONEMES;
          r.used   = 1'b1;
        end else if (c.is_quote) begin
          r.tbegin = nxt;
          r.state  = ST_STRING;
          r.used   = 1'b1;
        end else begin
          r.tbegin = pos;
          r.state  = ST_TEXT;
        end
      end
      ST_LINE: begin
        if (c.is_eol || c.is_hash) begin
          r.state = ST_START;
        end else if (c.is_tab || c.is_space) begin
          r.used = 1'b1;
        end else if (c.is_slash) begin
          r.tbegin = nxt;
          r.state  = ST_PHONEMES;
          r.used   = 1'b1;
        end else if (c.is_quote) begin
          r.tbegin = nxt;
          r.state  = ST_STRING;
          r.used   = 1'b1;
        end else begin
          r.tbegin = pos;
          r.state  = ST_TEXT;
        end
      end
      ST_COMMENT: begin
        if (c.is_eol) begin
          r.state = ST_START;
        end else begin
          r.used = 1'b1;
        end
      end
      ST_DIRECTIVE: begin
        if (c.is_eol || c.is_hash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_ERR_BODY;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_START;
        end else if (c.is_tab) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_DIRECTIVE;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_PRE_BODY;
        end else begin
          r.used = 1'b1;
        end
      end
      ST_PRE_BODY: begin
        if (c.is_eol || c.is_hash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_ERR_BODY;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_START;
        end else if (c.is_tab) begin
          r.used = 1'b1;
        end else if (c.is_quote) begin
          r.tbegin = nxt;
          r.state  = ST_DIR_STRING;
          r.used   = 1'b1;
        end else begin
          r.tbegin = pos;
          r.trim   = nxt;
          r.state  = ST_BODY;
          r.used   = 1'b1;
        end
      end
      ST_BODY: begin
        if (c.is_eol || c.is_hash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_CONTENTS;
          r.tstart = p.tbegin;
          r.tend   = p.trim;
          r.state  = ST_START;
        end else begin
          if (!c.is_space) begin
            r.trim = nxt;
          end
          r.used = 1'b1;
        end
      end
      ST_PHONEMES: begin
        if (c.is_eol || c.is_tab || c.is_hash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_ERR_SLASH;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_START;
        end else if (c.is_slash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_PHONEMES;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_LINE;
          r.used   = 1'b1;
        end else begin
          r.used = 1'b1;
        end
      end
      ST_TEXT: begin
        if (c.is_eol || c.is_tab || c.is_space || c.is_hash) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_TEXT;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = c.is_tab ? ST_LINE : ST_START;
        end else begin
          r.used = 1'b1;
        end
      end
      ST_DIR_STRING, ST_STRING: begin
        if (c.is_eol || c.is_tab) begin
          r.hit    = 1'b1;
          r.kind   = dlt_pkg::KIND_ERR_QUOTE;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.state  = ST_START;
        end else if (c.is_quote) begin
          r.hit    = 1'b1;
          r.tstart = p.tbegin;
          r.tend   = pos;
          r.used   = 1'b1;
          if (p.state == ST_STRING) begin
            r.kind  = dlt_pkg::KIND_STRING;
            r.state = ST_LINE;
          end else begin
            r.kind  = dlt_pkg::KIND_CONTENTS;
            r.state = ST_START;
          end
        end else begin
          r.used = 1'b1;
        end
      end
      default: begin
        r.state = ST_START;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] to_offset(pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  assign nxt_pos  = work_pos + 1'b1;
  assign go       = !work_empty && !res_full;
  assign work_pop = go;

  // A byte is handed on to the next state at most twice before some state uses it up.
  always_comb begin
    chain[0].state  = state_r;
    chain[0].used   = 1'b0;
    chain[0].hit    = 1'b0;
    chain[0].kind   = dlt_pkg::KIND_TEXT;
    chain[0].tstart = begin_r;
    chain[0].tend   = work_pos;
    chain[0].tbegin = begin_r;
    chain[0].trim   = trim_r;
    for (int i = 0; i < 3; i++) begin
      chain[i+1] = chain[i].used ? chain[i] : lex_step(chain[i], work_class, work_pos, nxt_pos);
    end
  end

  always_comb begin
    state_nxt            = state_r;
    begin_nxt            = begin_r;
    trim_nxt             = trim_r;
    res_push             = 1'b0;
    res_data.token_kind  = chain[3].kind;
    res_data.token_start = to_offset(chain[3].tstart);
    res_data.token_end   = to_offset(chain[3].tend);
    if (go) begin
      if (work_end) begin
        state_nxt            = ST_START;
        begin_nxt            = '0;
        trim_nxt             = '0;
        res_push             = 1'b1;
        res_data.token_kind  = dlt_pkg::KIND_END;
        res_data.token_start = to_offset(work_pos);
        res_data.token_end   = to_offset(work_pos);
      end else begin
        state_nxt = chain[3].state;
        begin_nxt = chain[3].tbegin;
        trim_nxt  = chain[3].trim;
        res_push  = chain[3].hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      begin_r <= '0;
      trim_r  <= '0;
    end else begin
      state_r <= state_nxt;
      begin_r <= begin_nxt;
      trim_r  <= trim_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full && !work_empty)
    else $error("Result produced without a byte to process or room to hold it.");

  assert property (@(posedge clk) disable iff (!rst_n)
      (go && work_end) |-> (res_push && res_data.token_kind == dlt_pkg::KIND_END))
    else $error("End marker did not give an end-of-stream result.");

  assert property (@(posedge clk) disable iff (!rst_n)
      (go && work_end) |=> (state_r == ST_START && begin_r == '0 && trim_r == '0))
    else $error("Lexer state not cleared after an end marker.");

  assert property (@(posedge clk) disable iff (!rst_n) (work_empty || res_full) |=> $stable(state_r))
    else $error("Lexer state moved while no byte was processed.");

endmodule

@@ hdl/dictionary_line_tokenizer.sv @@
// Top level of the dictionary line tokenizer: front stage, work queue, lexer and result queue.
// Depends on dlt_pkg, dlt_front, dlt_fifo and dlt_back.
//
// The block takes one text byte per request and returns at most one token per byte, giving its
// kind with start and exclusive end offsets; an end marker returns an end-of-stream result,
// drops any open token and restarts offsets at zero. One byte is accepted every clock cycle
// when the result side keeps up, because the lexer settles each byte, including any hand-on to
// a following state, in a single pass. A result reaches the result ports only after its byte
// has been registered in the work queue and the lexer has pushed its token into the result
// queue; the lexer decides combinationally between the two queues, and both queues are two
// entries deep.
module dictionary_line_tokenizer #(
  parameter int POSITION_BITS = dlt_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  dlt_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output dlt_pkg::out_item_t out_data
);

  localparam int WorkW = 1 + $bits(dlt_pkg::char_class_t) + POSITION_BITS;
  localparam int ResW  = $bits(dlt_pkg::out_item_t);

  typedef struct packed {
    logic                     end_mark;
    dlt_pkg::char_class_t     cls;
    logic [POSITION_BITS-1:0] pos;
  } work_t;

  work_t              wq_in, wq_out;
  logic               wq_push, wq_full, wq_empty, wq_pop;
  logic               rq_push, rq_full;
  dlt_pkg::out_item_t rq_in;

  dlt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .work_full  (wq_full),
    .work_push  (wq_push),
    .work_end   (wq_in.end_mark),
    .work_class (wq_in.cls),
    .work_pos   (wq_in.pos)
  );

  assign full = wq_full;

  dlt_fifo #(.WIDTH(WorkW), .DEPTH(dlt_pkg::WORK_DEPTH)) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (wq_push),
    .wr_data (wq_in),
    .full    (wq_full),
    .pop     (wq_pop),
    .rd_data (wq_out),
    .empty   (wq_empty)
  );

  dlt_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_empty (wq_empty),
    .work_end   (wq_out.end_mark),
    .work_class (wq_out.cls),
    .work_pos   (wq_out.pos),
    .work_pop   (wq_pop),
    .res_full   (rq_full),
    .res_push   (rq_push),
    .res_data   (rq_in)
  );

  dlt_fifo #(.WIDTH(ResW), .DEPTH(dlt_pkg::RESULT_DEPTH)) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_in),
    .full    (rq_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

@@ test/tb_token_pkg.sv @@
// Token tracker for the dictionary line tokenizer testbench: predicts the token of each
// accepted byte request and checks the results that come back. Depends on dlt_pkg.
package tb_token_pkg;

  typedef enum logic [3:0] {
    LX_START,
    LX_LINE,
    LX_COMMENT,
    LX_DIRECTIVE,
    LX_PRE_BODY,
    LX_BODY,
    LX_TEXT,
    LX_PHONEMES,
    LX_DIR_STRING,
    LX_STRING
  } lex_state_e;

  class token_ledger;
    lex_state_e           state;
    logic [31:0]          position;
    logic [31:0]          begin_at;
    logic [31:0]          trimmed_end;
    dlt_pkg::out_item_t   awaited[$];
    int                   mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      state = LX_START;
      position = '0;
      begin_at = '0;
      trimmed_end = '0;
    endfunction

    function void emit(dlt_pkg::kind_t k, logic [31:0] s, logic [31:0] e);
      dlt_pkg::out_item_t tok;
      tok.token_kind = k;
      tok.token_start = s;
      tok.token_end = e;
      awaited.push_back(tok);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function void note_byte(dlt_pkg::in_item_t req);
      logic [7:0]  c;
      logic [31:0] here;
      logic [31:0] after;
      bit          consumed;
      bit          eol;
      int          g;
      c = req.data_byte;
      here = position;
      after = position + 32'd1;
      consumed = 0;
      if (req.end_of_input) begin
        emit(dlt_pkg::KIND_END, here, here);
        restart();
        return;
      end
      eol = (c == dlt_pkg::CH_CR) || (c == dlt_pkg::CH_LF);
      for (g = 0; g < 8 && !consumed; g++) begin
        case (state)
          LX_START: begin
            if (eol || c == dlt_pkg::CH_TAB || c == dlt_pkg::CH_SPACE) consumed = 1;
            else if (c == dlt_pkg::CH_HASH) state = LX_COMMENT;
            else if (c == dlt_pkg::CH_DOT) begin
              begin_at = here;
              state = LX_DIRECTIVE;
            end else if (c == dlt_pkg::CH_SLASH) begin
              begin_at = after;
              state = LX_PHONEMES;
              consumed = 1;
            end else if (c == dlt_pkg::CH_QUOTE) begin
              begin_at = after;
              state = LX_STRING;
              consumed = 1;
            end else begin
              begin_at = here;
              state = LX_TEXT;
            end
          end
          LX_LINE: begin
            if (eol || c == dlt_pkg::CH_HASH) state = LX_START;
            else if (c == dlt_pkg::CH_TAB || c == dlt_pkg::CH_SPACE) consumed = 1;
            else if (c == dlt_pkg::CH_SLASH) begin
              begin_at = after;
              state = LX_PHONEMES;
              consumed = 1;
            end else if (c == dlt_pkg::CH_QUOTE) begin
              begin_at = after;
              state = LX_STRING;
              consumed = 1;
            end else begin
              begin_at = here;
              state = LX_TEXT;
            end
          end
          LX_COMMENT: begin
            if (eol) state = LX_START;
            else consumed = 1;
          end
          LX_DIRECTIVE: begin
            if (eol || c == dlt_pkg::CH_HASH) begin
              emit(dlt_pkg::KIND_ERR_BODY, begin_at, here);
              state = LX_START;
            end else if (c == dlt_pkg::CH_TAB) begin
              emit(dlt_pkg::KIND_DIRECTIVE, begin_at, here);
              state = LX_PRE_BODY;
            end else consumed = 1;
          end
          LX_PRE_BODY: begin
            if (eol || c == dlt_pkg::CH_HASH) begin
              emit(dlt_pkg::KIND_ERR_BODY, begin_at, here);
              state = LX_START;
            end else if (c == dlt_pkg::CH_TAB) consumed = 1;
            else if (c == dlt_pkg::CH_QUOTE) begin
              begin_at = after;
              state = LX_DIR_STRING;
              consumed = 1;
            end else begin
              begin_at = here;
              trimmed_end = after;
              state = LX_BODY;
              consumed = 1;
            end
          end
          LX_BODY: begin
            if (eol || c == dlt_pkg::CH_HASH) begin
              emit(dlt_pkg::KIND_CONTENTS, begin_at, trimmed_end);
              state = LX_START;
            end else begin
              if (c != dlt_pkg::CH_SPACE) trimmed_end = after;
              consumed = 1;
            end
          end
          LX_PHONEMES: begin
            if (eol || c == dlt_pkg::CH_TAB || c == dlt_pkg::CH_HASH) begin
              emit(dlt_pkg::KIND_ERR_SLASH, begin_at, here);
              state = LX_START;
            end else if (c == dlt_pkg::CH_SLASH) begin
              emit(dlt_pkg::KIND_PHONEMES, begin_at, here);
              state = LX_LINE;
              consumed = 1;
            end else consumed = 1;
          end
          LX_TEXT: begin
            if (eol || c == dlt_pkg::CH_TAB || c == dlt_pkg::CH_SPACE ||
                c == dlt_pkg::CH_HASH) begin
              emit(dlt_pkg::KIND_TEXT, begin_at, here);
              state = (c == dlt_pkg::CH_TAB) ? LX_LINE : LX_START;
            end else consumed = 1;
          end
          LX_DIR_STRING, LX_STRING: begin
            if (eol || c == dlt_pkg::CH_TAB) begin
              emit(dlt_pkg::KIND_ERR_QUOTE, begin_at, here);
              state = LX_START;
            end else if (c == dlt_pkg::CH_QUOTE) begin
              if (state == LX_STRING) begin
                emit(dlt_pkg::KIND_STRING, begin_at, here);
                state = LX_LINE;
              end else begin
                emit(dlt_pkg::KIND_CONTENTS, begin_at, here);
                state = LX_START;
              end
              consumed = 1;
            end else consumed = 1;
          end
          default: state = LX_START;
        endcase
      end
      position = after;
    endfunction

    task check_token(dlt_pkg::out_item_t got);
      dlt_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with no token awaited", got.token_kind));
        return;
      end
      want = awaited.pop_front();
      if (got.token_kind !== want.token_kind)
        report_mismatch($sformatf("token_kind %0d, wanted %0d", got.token_kind,
                                  want.token_kind));
      if (got.token_start !== want.token_start)
        report_mismatch($sformatf("token_start %0d, wanted %0d", got.token_start,
                                  want.token_start));
      if (got.token_end !== want.token_end)
        report_mismatch($sformatf("token_end %0d, wanted %0d", got.token_end,
                                  want.token_end));
    endtask
  endclass

endpackage

@@ test/tb_top.sv @@
// Top of the dictionary line tokenizer testbench: clock, reset, request drivers and stimulus.
// Depends on dlt_pkg, tb_token_pkg and the dictionary_line_tokenizer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  dlt_pkg::in_item_t  in_data;
  logic               empty;
  logic               pop;
  dlt_pkg::out_item_t out_data;

  tb_token_pkg::token_ledger ledger = new();
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_off_req;
  int          sent;

  dictionary_line_tokenizer dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) ledger.note_byte(in_data);
      if (pop && !empty) ledger.check_token(out_data);
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] word_char();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'h61, 8'h7a))
                                      : 8'($urandom_range(8'h80, 8'hff));
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(0, 1) ? dlt_pkg::CH_LF : dlt_pkg::CH_CR;
  endfunction

  task automatic send_request(dlt_pkg::in_item_t req);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap_len() - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    dlt_pkg::in_item_t req;
    req.data_byte = b;
    req.end_of_input = 1'b0;
    send_request(req);
  endtask

  task automatic send_end();
    dlt_pkg::in_item_t req;
    req.data_byte = 8'($urandom_range(0, 255));
    req.end_of_input = 1'b1;
    send_request(req);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic random_line();
    int pick;
    int words;
    int w;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(dlt_pkg::CH_DOT);
      repeat ($urandom_range(0, 4)) send_byte(word_char());
      if ($urandom_range(0, 7) != 0) begin
        repeat ($urandom_range(1, 2)) send_byte(dlt_pkg::CH_TAB);
        if ($urandom_range(0, 3) == 0) begin
          send_byte(dlt_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) send_byte(word_char());
          if ($urandom_range(0, 5) != 0) send_byte(dlt_pkg::CH_QUOTE);
        end else begin
          repeat ($urandom_range(1, 6))
            send_byte(($urandom_range(0, 4) == 0) ? dlt_pkg::CH_SPACE : word_char());
          repeat ($urandom_range(0, 3)) send_byte(dlt_pkg::CH_SPACE);
        end
      end
      send_byte(($urandom_range(0, 5) == 0) ? dlt_pkg::CH_HASH : line_end());
    end else if (pick < 75) begin
      words = $urandom_range(1, 5);
      for (w = 0; w < words; w++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          repeat ($urandom_range(1, 6)) send_byte(word_char());
        end else if (pick < 7) begin
          send_byte(dlt_pkg::CH_SLASH);
          repeat ($urandom_range(0, 5)) send_byte(word_char());
          if ($urandom_range(0, 7) != 0) send_byte(dlt_pkg::CH_SLASH);
        end else begin
          send_byte(dlt_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5))
            send_byte(($urandom_range(0, 5) == 0) ? dlt_pkg::CH_SPACE : word_char());
          if ($urandom_range(0, 7) != 0) send_byte(dlt_pkg::CH_QUOTE);
        end
        repeat ($urandom_range(1, 2))
          send_byte($urandom_range(0, 2) == 0 ? dlt_pkg::CH_TAB : dlt_pkg::CH_SPACE);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(dlt_pkg::CH_HASH);
        repeat ($urandom_range(0, 4)) send_byte(word_char());
      end
      send_byte(line_end());
    end else if (pick < 85) begin
      send_byte(dlt_pkg::CH_HASH);
      repeat ($urandom_range(0, 6))
        send_byte(($urandom_range(0, 3) == 0) ? dlt_pkg::CH_SPACE : word_char());
      send_byte(line_end());
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_end();
    end
  endtask

  task automatic random_until(int target);
    while (sent < target) random_line();
  endtask

  initial begin : result_side
    int n;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off_req = 0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    sent = 0;
    tx_gaps = 0;
    rx_gaps = 0;
    hold_off_req = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A directive whose body is only spaces, then each token kind and each error.
    send_text(".d\t  \n");
    send_byte(dlt_pkg::CH_SLASH);
    send_byte(8'h00);
    send_byte(dlt_pkg::CH_SLASH);
    send_byte(dlt_pkg::CH_QUOTE);
    send_byte(8'hff);
    send_byte(dlt_pkg::CH_QUOTE);
    send_text(" w\r#\n.\n/\t\"\n.\t\"\"");
    send_end();

    @(negedge clk);
    push <= 1'b0;
    wait_drained();

    tx_gaps = 1;
    rx_gaps = 1;
    random_until(250);

    // The result side holds off while requests keep coming, so the block fills up.
    tx_gaps = 0;
    hold_off_req = 1;
    random_until(sent + 30);
    @(negedge clk);
    push <= 1'b0;
    wait_drained();

    rx_gaps = 0;
    random_until(400);

    tx_gaps = 1;
    rx_gaps = 1;
    random_until(550);

    @(negedge clk);
    push <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dlt_pkg.sv
hdl/dlt_fifo.sv
hdl/dlt_front.sv
hdl/dlt_back.sv
hdl/dictionary_line_tokenizer.sv
test/tb_token_pkg.sv
test/tb_top.sv
